/* hdl/qrv_pkg.sv */
// qrv_pkg: widths, word types and sideband structs of the quaternion rotation pipeline
// used by qrv_isqrt, qrv_div and quaternion_rotate_vector; depends on nothing
`default_nettype none

package qrv_pkg;

    localparam int QW    = 16;          // quaternion component, Q2.14
    localparam int VW    = 32;          // vector component
    localparam int UF    = 24;          // fraction bits of the unit quaternion
    localparam int UW    = UF + 2;      // signed unit component, |u| <= 2^UF
    localparam int QBITS = UF + 1;      // quotient bits per lane
    localparam int XW    = 63;          // squared norm shifted left by 30
    localparam int SW    = 32;          // root width
    localparam int RSH   = QW - 2;      // first partial remainder is mag << RSH
    localparam int PW    = VW + 3;      // first product result
    localparam int MW1   = UW + VW;
    localparam int MW2   = UW + PW;
    localparam int AW    = 64;          // accumulation width

    typedef struct packed {
        logic signed [QW-1:0] quat_x;
        logic signed [QW-1:0] quat_y;
        logic signed [QW-1:0] quat_z;
        logic signed [QW-1:0] quat_w;
        logic signed [VW-1:0] vec_x;
        logic signed [VW-1:0] vec_y;
        logic signed [VW-1:0] vec_z;
    } t_in_word;

    typedef struct packed {
        logic signed [VW-1:0] rot_x;
        logic signed [VW-1:0] rot_y;
        logic signed [VW-1:0] rot_z;
    } t_out_word;

    typedef struct packed {
        logic                  zero;
        logic [3:0]            sign;
        logic [3:0][QW-1:0]    mag;
        logic [2:0][VW-1:0]    vec;
    } t_sqrt_tag;

    typedef struct packed {
        logic                  zero;
        logic [3:0]            sign;
        logic [2:0][VW-1:0]    vec;
    } t_div_tag;

endpackage

`default_nettype wire

/* hdl/quaternion_rotate_vector.sv */
// quaternion_rotate_vector: normalize q, then rotate v as q * v * conj(q), saturated
// depends on qrv_pkg, qrv_isqrt, qrv_div
//
//  channel  direction  handshake            word
//  input    in         i_valid / o_ready    i_data  (qrv_pkg::t_in_word)
//  output   out        o_valid / i_ready    o_data  (qrv_pkg::t_out_word)
//
// one word per cycle while the output is not held (o_valid high and i_ready low)
// the datapath runs through the 33-register square root and the 26-register quotient pipeline
// synchronous active-low reset clears the valid bits only
// the whole pipeline holds while o_valid is high and i_ready low; o_ready follows
`default_nettype none

module quaternion_rotate_vector (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire qrv_pkg::t_in_word     i_data,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output qrv_pkg::t_out_word         o_data
);

    localparam int UF  = qrv_pkg::UF;
    localparam int UW  = qrv_pkg::UW;
    localparam int VW  = qrv_pkg::VW;
    localparam int QW  = qrv_pkg::QW;
    localparam int AW  = qrv_pkg::AW;
    localparam int PW  = qrv_pkg::PW;
    localparam logic signed [AW-1:0] HALF = AW'(1) <<< (UF - 1);
    localparam logic signed [AW-1:0] SMAX = (AW'(1) <<< (VW - 1)) - AW'(1);
    localparam logic signed [AW-1:0] SMIN = -SMAX - AW'(1);
    localparam logic signed [UW-1:0] UMAX = UW'(1) <<< UF;
    localparam logic signed [UW-1:0] UMIN = -UMAX;

    function automatic logic signed [AW-1:0] rnd(input logic signed [AW-1:0] x);
        return (x + HALF) >>> UF;
    endfunction

    function automatic logic signed [VW-1:0] sat(input logic signed [AW-1:0] x);
        if (x > SMAX) begin
            return VW'(SMAX);
        end else if (x < SMIN) begin
            return VW'(SMIN);
        end
        return VW'(x);
    endfunction

    logic w_en;
    assign w_en    = ~o_valid | i_ready;
    assign o_ready = w_en;

    // input register
    qrv_pkg::t_in_word r_in;
    logic              r_vld_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_in <= 1'b0;
        end else if (w_en) begin
            r_vld_in <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_in <= i_data;
        end
    end

    // squares and sideband
    logic signed [QW-1:0] w_a [0:3];
    assign w_a[0] = r_in.quat_x;
    assign w_a[1] = r_in.quat_y;
    assign w_a[2] = r_in.quat_z;
    assign w_a[3] = r_in.quat_w;

    logic signed [2*QW-1:0] w_sq [0:3];
    for (genvar n = 0; n < 4; n++) begin : g_sq
        assign w_sq[n] = w_a[n] * w_a[n];
    end

    logic [2*QW-1:0]      r_sq [0:3];
    qrv_pkg::t_sqrt_tag   r_tag_sq;
    logic                 r_vld_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_sq <= 1'b0;
        end else if (w_en) begin
            r_vld_sq <= r_vld_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int l = 0; l < 4; l++) begin
                r_sq[l]          <= w_sq[l];
                r_tag_sq.sign[l] <= w_a[l][QW-1];
                r_tag_sq.mag[l]  <= w_a[l][QW-1] ? QW'(~w_a[l] + QW'(1)) : QW'(w_a[l]);
            end
            r_tag_sq.zero   <= (w_a[0] == '0) && (w_a[1] == '0) &&
                               (w_a[2] == '0) && (w_a[3] == '0);
            r_tag_sq.vec[0] <= r_in.vec_x;
            r_tag_sq.vec[1] <= r_in.vec_y;
            r_tag_sq.vec[2] <= r_in.vec_z;
        end
    end

    logic [2*QW:0]             w_norm2;
    logic [qrv_pkg::XW-1:0]    w_x;
    assign w_norm2 = (2*QW+1)'(r_sq[0]) + (2*QW+1)'(r_sq[1]) +
                     (2*QW+1)'(r_sq[2]) + (2*QW+1)'(r_sq[3]);
    assign w_x     = qrv_pkg::XW'({w_norm2, 30'b0});

    logic                      w_sqrt_vld;
    logic [qrv_pkg::SW-1:0]    w_root;
    qrv_pkg::t_sqrt_tag        w_sqrt_tag;

    qrv_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_vld_sq),
        .i_x     (w_x),
        .i_tag   (r_tag_sq),
        .o_vld   (w_sqrt_vld),
        .o_root  (w_root),
        .o_tag   (w_sqrt_tag)
    );

    qrv_pkg::t_div_tag w_div_in_tag;
    assign w_div_in_tag.zero = w_sqrt_tag.zero;
    assign w_div_in_tag.sign = w_sqrt_tag.sign;
    assign w_div_in_tag.vec  = w_sqrt_tag.vec;

    logic                                  w_div_vld;
    logic [3:0][qrv_pkg::QBITS-1:0]        w_quot;
    qrv_pkg::t_div_tag                     w_div_tag;

    qrv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_sqrt_vld),
        .i_s     (w_root),
        .i_mag   (w_sqrt_tag.mag),
        .i_tag   (w_div_in_tag),
        .o_vld   (w_div_vld),
        .o_quot  (w_quot),
        .o_tag   (w_div_tag)
    );

    // stage a: signed unit quaternion
    logic signed [UW-1:0] r_u_a [0:3];
    logic signed [VW-1:0] r_v_a [0:2];
    logic                 r_zero_a, r_vld_a;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int l = 0; l < 4; l++) begin
                r_u_a[l] <= w_div_tag.sign[l] ? -$signed(UW'(w_quot[l]))
                                              :  $signed(UW'(w_quot[l]));
            end
            for (int j = 0; j < 3; j++) begin
                r_v_a[j] <= $signed(w_div_tag.vec[j]);
            end
            r_zero_a <= w_div_tag.zero;
        end
    end

    // stage b: u * v products
    logic signed [qrv_pkg::MW1-1:0] r_m1 [0:11];
    logic signed [UW-1:0]           r_u_b [0:3];
    logic                           r_zero_b, r_vld_b;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_m1[i*3+j] <= qrv_pkg::MW1'(r_u_a[i] * r_v_a[j]);
                end
                r_u_b[i] <= r_u_a[i];
            end
            r_zero_b <= r_zero_a;
        end
    end

    // stage c: first hamilton product, index 0 is the scalar part
    logic signed [AW-1:0] w_e1 [0:11];
    logic signed [AW-1:0] w_ps [0:3];
    for (genvar n = 0; n < 12; n++) begin : g_e1
        assign w_e1[n] = AW'(r_m1[n]);
    end
    assign w_ps[0] = -w_e1[0] - w_e1[4]  - w_e1[8];
    assign w_ps[1] =  w_e1[9] + w_e1[5]  - w_e1[7];
    assign w_ps[2] =  w_e1[10] - w_e1[2] + w_e1[6];
    assign w_ps[3] =  w_e1[11] + w_e1[1] - w_e1[3];

    logic signed [PW-1:0] r_p_c [0:3];
    logic signed [UW-1:0] r_u_c [0:3];
    logic                 r_zero_c, r_vld_c;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 4; i++) begin
                r_p_c[i] <= PW'(rnd(w_ps[i]));
                r_u_c[i] <= r_u_b[i];
            end
            r_zero_c <= r_zero_b;
        end
    end

    // stage d: p * conj(u) products
    logic signed [qrv_pkg::MW2-1:0] r_m2 [0:11];
    logic                           r_zero_d, r_vld_d;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m2[0]  <= qrv_pkg::MW2'(r_p_c[0] * r_u_c[0]);
            r_m2[1]  <= qrv_pkg::MW2'(r_p_c[1] * r_u_c[3]);
            r_m2[2]  <= qrv_pkg::MW2'(r_p_c[2] * r_u_c[2]);
            r_m2[3]  <= qrv_pkg::MW2'(r_p_c[3] * r_u_c[1]);
            r_m2[4]  <= qrv_pkg::MW2'(r_p_c[0] * r_u_c[1]);
            r_m2[5]  <= qrv_pkg::MW2'(r_p_c[1] * r_u_c[2]);
            r_m2[6]  <= qrv_pkg::MW2'(r_p_c[2] * r_u_c[3]);
            r_m2[7]  <= qrv_pkg::MW2'(r_p_c[3] * r_u_c[0]);
            r_m2[8]  <= qrv_pkg::MW2'(r_p_c[0] * r_u_c[2]);
            r_m2[9]  <= qrv_pkg::MW2'(r_p_c[1] * r_u_c[1]);
            r_m2[10] <= qrv_pkg::MW2'(r_p_c[2] * r_u_c[0]);
            r_m2[11] <= qrv_pkg::MW2'(r_p_c[3] * r_u_c[3]);
            r_zero_d <= r_zero_c;
        end
    end

    // stage e: second product, rounding, saturation; a zero quaternion gives a zero output
    logic signed [AW-1:0] w_e2 [0:11];
    logic signed [AW-1:0] w_rs [0:2];
    for (genvar n = 0; n < 12; n++) begin : g_e2
        assign w_e2[n] = AW'(r_m2[n]);
    end
    assign w_rs[0] = -w_e2[0] + w_e2[1] - w_e2[2]  + w_e2[3];
    assign w_rs[1] = -w_e2[4] + w_e2[5] + w_e2[6]  - w_e2[7];
    assign w_rs[2] = -w_e2[8] - w_e2[9] + w_e2[10] + w_e2[11];

    qrv_pkg::t_out_word r_out;
    logic               r_vld_e;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r_zero_d) begin
                r_out <= '0;
            end else begin
                r_out.rot_x <= sat(rnd(w_rs[0]));
                r_out.rot_y <= sat(rnd(w_rs[1]));
                r_out.rot_z <= sat(rnd(w_rs[2]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
            r_vld_c <= 1'b0;
            r_vld_d <= 1'b0;
            r_vld_e <= 1'b0;
        end else if (w_en) begin
            r_vld_a <= w_div_vld;
            r_vld_b <= r_vld_a;
            r_vld_c <= r_vld_b;
            r_vld_d <= r_vld_c;
            r_vld_e <= r_vld_d;
        end
    end

    assign o_valid = r_vld_e;
    assign o_data  = r_out;

    // a nonzero quaternion always has a nonzero root
    a_root_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sqrt_vld && !w_sqrt_tag.zero |-> w_root != '0)
        else $error("zero root for nonzero quaternion");

    // normalized components stay within one
    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld_a && !r_zero_a |->
            r_u_a[0] <= UMAX && r_u_a[0] >= UMIN && r_u_a[1] <= UMAX && r_u_a[1] >= UMIN &&
            r_u_a[2] <= UMAX && r_u_a[2] >= UMIN && r_u_a[3] <= UMAX && r_u_a[3] >= UMIN)
        else $error("unit quaternion component out of range");

    // a held output stalls the tail of the pipeline
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(r_vld_d) && $stable(r_vld_a) && o_valid)
        else $error("pipeline moved during stall");

endmodule

`default_nettype wire

/* hdl/qrv_isqrt.sv */
// qrv_isqrt: pipelined integer square root, one result bit per stage
// carries the quaternion sideband alongside; depends on qrv_pkg
`default_nettype none

module qrv_isqrt (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_en,
    input  wire logic                      i_vld,
    input  wire logic [qrv_pkg::XW-1:0]    i_x,
    input  wire qrv_pkg::t_sqrt_tag        i_tag,
    output logic                           o_vld,
    output logic [qrv_pkg::SW-1:0]         o_root,
    output qrv_pkg::t_sqrt_tag             o_tag
);

    localparam int NS = (qrv_pkg::XW + 1) / 2;

    logic [qrv_pkg::XW-1:0] r_x   [0:NS];
    logic [qrv_pkg::XW-1:0] r_res [0:NS];
    qrv_pkg::t_sqrt_tag     r_tag [0:NS];
    logic [NS:0]            r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]   <= i_x;
            r_res[0] <= '0;
            r_tag[0] <= i_tag;
        end
    end

    for (genvar k = 0; k < NS; k++) begin : g_step
        localparam logic [qrv_pkg::XW-1:0] BIT =
            qrv_pkg::XW'(1) << (qrv_pkg::XW - 1 - 2 * k);
        logic [qrv_pkg::XW-1:0] n_t;
        logic [qrv_pkg::XW-1:0] n_x;
        logic [qrv_pkg::XW-1:0] n_res;
        logic                   n_ge;

        always_comb begin
            n_t  = r_res[k] + BIT;
            n_ge = (r_x[k] >= n_t);
            if (n_ge) begin
                n_x   = r_x[k] - n_t;
                n_res = (r_res[k] >> 1) + BIT;
            end else begin
                n_x   = r_x[k];
                n_res = r_res[k] >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[k+1]   <= n_x;
                r_res[k+1] <= n_res;
                r_tag[k+1] <= r_tag[k];
            end
        end
    end

    assign o_vld  = r_vld[NS];
    assign o_root = r_res[NS][qrv_pkg::SW-1:0];
    assign o_tag  = r_tag[NS];

endmodule

`default_nettype wire

/* hdl/qrv_div.sv */
// qrv_div: four-lane restoring divider, |a_i| * 2^(UF+15) / s, one quotient bit per stage
// carries the sign/vector sideband alongside; depends on qrv_pkg
`default_nettype none

module qrv_div (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_en,
    input  wire logic                              i_vld,
    input  wire logic [qrv_pkg::SW-1:0]            i_s,
    input  wire logic [3:0][qrv_pkg::QW-1:0]       i_mag,
    input  wire qrv_pkg::t_div_tag                 i_tag,
    output logic                                   o_vld,
    output logic [3:0][qrv_pkg::QBITS-1:0]         o_quot,
    output qrv_pkg::t_div_tag                      o_tag
);

    localparam int NS = qrv_pkg::QBITS;
    localparam int RW = qrv_pkg::SW + 1;

    logic [qrv_pkg::SW-1:0]          r_s   [0:NS];
    logic [3:0][RW-1:0]              r_rem [0:NS];
    logic [3:0][qrv_pkg::QBITS-1:0]  r_q   [0:NS];
    qrv_pkg::t_div_tag               r_tag [0:NS];
    logic [NS:0]                     r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
    end

    // quotient never exceeds 2^UF since s >= |a_i| * 2^15
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s[0]   <= i_s;
            r_q[0]   <= '0;
            r_tag[0] <= i_tag;
            for (int l = 0; l < 4; l++) begin
                r_rem[0][l] <= RW'({i_mag[l], {qrv_pkg::RSH{1'b0}}});
            end
        end
    end

    for (genvar k = 0; k < NS; k++) begin : g_step
        logic [3:0][RW-1:0]             n_rem;
        logic [3:0][qrv_pkg::QBITS-1:0] n_q;

        always_comb begin
            logic [RW:0] v_r2;
            for (int l = 0; l < 4; l++) begin
                v_r2 = {r_rem[k][l], 1'b0};
                if (v_r2 >= {2'b00, r_s[k]}) begin
                    n_rem[l] = RW'(v_r2 - {2'b00, r_s[k]});
                    n_q[l]   = {r_q[k][l][qrv_pkg::QBITS-2:0], 1'b1};
                end else begin
                    n_rem[l] = RW'(v_r2);
                    n_q[l]   = {r_q[k][l][qrv_pkg::QBITS-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_s[k+1]   <= r_s[k];
                r_rem[k+1] <= n_rem;
                r_q[k+1]   <= n_q;
                r_tag[k+1] <= r_tag[k];
            end
        end
    end

    assign o_vld  = r_vld[NS];
    assign o_quot = r_q[NS];
    assign o_tag  = r_tag[NS];

endmodule

`default_nettype wire
